// File: rtl/bwt_occurrence_checkpoint_interleaver_unit_macros.svh
// Assertion macros for the checker file of the occurrence interleaver.
// No dependencies; taken in by `include.
`ifndef BWT_OCCURRENCE_CHECKPOINT_INTERLEAVER_UNIT_MACROS_SVH
`define BWT_OCCURRENCE_CHECKPOINT_INTERLEAVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BOCIL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held
`define BOCIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/bocil_pkg.sv
// Shared types and constants for the occurrence checkpoint interleaver.
// No dependencies.
`default_nettype none

package bocil_pkg;

    localparam int LANES          = 16;   // symbols per packed word
    localparam int SYM_W          = 2;
    localparam int NUM_SYMS       = 4;
    localparam int WORD_W         = 32;
    localparam int NVALID_W       = 5;
    localparam int COUNT_W        = 64;
    localparam int INCR_W         = 5;    // 0..16 hits per symbol per word
    localparam int PHASE_W        = 5;
    localparam int DEF_INTERVAL   = 128;

    // Emit phases: count halves 0..7, passed word, closing halves 9..16
    localparam logic [PHASE_W-1:0] PH_FIRST = 5'd0;
    localparam logic [PHASE_W-1:0] PH_WORD  = 5'd8;
    localparam logic [PHASE_W-1:0] PH_POST  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_LAST  = 5'd16;

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    typedef logic [INCR_W-1:0] t_incr [NUM_SYMS];

    // Item handed from the front end to the emitter
    typedef struct packed {
        logic [WORD_W-1:0]            word;
        logic [NUM_SYMS*INCR_W-1:0]   incr;      // symbol s at [s*INCR_W +: INCR_W]
        logic                         final_word;
        logic                         ckpt;      // emit checkpoint before the word
    } t_item;

endpackage

`default_nettype wire

// File: rtl/bocil_lane.sv
// One symbol lane: decodes a 2-bit symbol to a one-hot hit, masked by validity.
// Depends on bocil_pkg.
`default_nettype none

module bocil_lane #(
    parameter int LANE = 0
) (
    input  wire logic [bocil_pkg::SYM_W-1:0]    i_sym,
    input  wire logic [bocil_pkg::NVALID_W-1:0] i_valid_symbols,
    output logic      [bocil_pkg::NUM_SYMS-1:0] o_hit
);

    logic lane_valid;

    // lane counts only if it sits below the valid count (values above 16 saturate naturally)
    assign lane_valid = (i_valid_symbols > bocil_pkg::NVALID_W'(LANE));

    always_comb begin
        o_hit = '0;
        o_hit[i_sym] = lane_valid;
    end

endmodule

`default_nettype wire

// File: rtl/bocil_merge.sv
// Merge stage: sums the lane hits into one increment per symbol value.
// Depends on bocil_pkg.
`default_nettype none

module bocil_merge (
    input  wire logic [bocil_pkg::LANES*bocil_pkg::NUM_SYMS-1:0]  i_hits,
    output logic      [bocil_pkg::NUM_SYMS*bocil_pkg::INCR_W-1:0] o_incr
);

    logic [bocil_pkg::LANES-1:0] per_sym [bocil_pkg::NUM_SYMS];

    // regroup lane-major hits by symbol, then population count
    always_comb begin
        for (int s = 0; s < bocil_pkg::NUM_SYMS; s++) begin
            for (int j = 0; j < bocil_pkg::LANES; j++) begin
                per_sym[s][j] = i_hits[j*bocil_pkg::NUM_SYMS + s];
            end
            o_incr[s*bocil_pkg::INCR_W +: bocil_pkg::INCR_W] =
                bocil_pkg::INCR_W'($countones(per_sym[s]));
        end
    end

endmodule

`default_nettype wire

// File: rtl/bocil_emit.sv
// Emitter: holds one item, keeps the running counts, and sequences the
// count halves and passed word into a registered output. Depends on bocil_pkg.
`default_nettype none

module bocil_emit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    output logic                                o_item_ready,
    input  wire bocil_pkg::t_item               i_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [bocil_pkg::WORD_W-1:0]        o_out_word,
    output logic                                o_word_kind,
    output logic                                o_last_of_item,
    output logic                                o_index_end
);

    logic                              r_busy;
    logic [bocil_pkg::PHASE_W-1:0]     r_phase;
    bocil_pkg::t_item                  r_item;
    logic [bocil_pkg::COUNT_W-1:0]     r_counts [bocil_pkg::NUM_SYMS];
    logic                              r_out_valid;
    logic [bocil_pkg::WORD_W-1:0]      r_out_word;
    logic                              r_kind;
    logic                              r_last;
    logic                              r_end;

    logic                              out_free;
    logic                              step;
    logic                              last_res;
    logic                              take;
    logic [bocil_pkg::PHASE_W-1:0]     post_idx;
    logic [2:0]                        half_idx;
    logic [bocil_pkg::COUNT_W-1:0]     sel_count;
    logic [bocil_pkg::WORD_W-1:0]      n_word;
    logic                              n_kind;

    // advance one result whenever the output register frees up
    assign out_free     = !r_out_valid || i_out_ready;
    assign step         = r_busy && out_free;
    assign last_res     = (r_phase == bocil_pkg::PH_LAST) ||
                          ((r_phase == bocil_pkg::PH_WORD) && !r_item.final_word);
    assign o_item_ready = !r_busy || (step && last_res);
    assign take         = i_item_valid && o_item_ready;

    // pick the count half or the word for the current phase
    assign post_idx  = r_phase - bocil_pkg::PH_POST;
    assign half_idx  = (r_phase < bocil_pkg::PH_WORD) ? r_phase[2:0] : post_idx[2:0];
    assign sel_count = r_counts[half_idx[2:1]];

    always_comb begin
        if (r_phase == bocil_pkg::PH_WORD) begin
            n_word = r_item.word;
            n_kind = bocil_pkg::KIND_WORD;
        end else begin
            n_word = half_idx[0] ? sel_count[bocil_pkg::COUNT_W-1:bocil_pkg::WORD_W]
                                 : sel_count[bocil_pkg::WORD_W-1:0];
            n_kind = bocil_pkg::KIND_COUNT;
        end
    end

    // item slot and phase counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= bocil_pkg::PH_FIRST;
        end else if (take) begin
            r_busy  <= 1'b1;
            r_phase <= i_item.ckpt ? bocil_pkg::PH_FIRST : bocil_pkg::PH_WORD;
        end else if (step && last_res) begin
            r_busy  <= 1'b0;
        end else if (step) begin
            r_phase <= r_phase + bocil_pkg::PHASE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    // running counts: add after the word goes out, clear after the closing halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bocil_pkg::NUM_SYMS; s++) r_counts[s] <= '0;
        end else if (step && (r_phase == bocil_pkg::PH_WORD)) begin
            for (int s = 0; s < bocil_pkg::NUM_SYMS; s++) begin
                r_counts[s] <= r_counts[s] + bocil_pkg::COUNT_W'(
                    r_item.incr[s*bocil_pkg::INCR_W +: bocil_pkg::INCR_W]);
            end
        end else if (step && (r_phase == bocil_pkg::PH_LAST)) begin
            for (int s = 0; s < bocil_pkg::NUM_SYMS; s++) r_counts[s] <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= n_word;
            r_kind     <= n_kind;
            r_last     <= last_res;
            r_end      <= (r_phase == bocil_pkg::PH_LAST);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;
    assign o_word_kind    = r_kind;
    assign o_last_of_item = r_last;
    assign o_index_end    = r_end;

endmodule

`default_nettype wire

// File: rtl/bwt_occurrence_checkpoint_interleaver_unit.sv
// The first result of an accepted item passes through the item slot, then the output reg.
// Throughput: one output word per cycle from the emitter while the receiver is ready; an item
// gives its passed word, plus 8 count halves at a checkpoint and/or 8 closing halves on a final word.
// Average with interval 128: a checkpoint every 8 words, so 16 output words per 8 words, i.e. 2 per item.
// Reset (synchronous, active low): counts and word position cleared, no transaction pending.
// Depends on bocil_pkg, bocil_lane, bocil_merge, bocil_emit.
`default_nettype none

module bwt_occurrence_checkpoint_interleaver_unit #(
    parameter int CHECKPOINT_INTERVAL = bocil_pkg::DEF_INTERVAL
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [bocil_pkg::WORD_W-1:0]     i_packed_word,
    input  wire logic [bocil_pkg::NVALID_W-1:0]   i_valid_symbols,
    input  wire logic                             i_final_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [bocil_pkg::WORD_W-1:0]          o_out_word,
    output logic                                  o_word_kind,
    output logic                                  o_last_of_item,
    output logic                                  o_index_end
);

    localparam int WPI_RAW = CHECKPOINT_INTERVAL / bocil_pkg::LANES;
    localparam int WPI     = (WPI_RAW < 1) ? 1 : WPI_RAW;
    localparam int WII_W   = (WPI > 1) ? $clog2(WPI) : 1;

    logic [WII_W-1:0]                                       r_wii;
    logic [bocil_pkg::LANES*bocil_pkg::NUM_SYMS-1:0]        hits;
    logic [bocil_pkg::NUM_SYMS*bocil_pkg::INCR_W-1:0]       incr;
    bocil_pkg::t_item                                       item;
    logic                                                   accept;

    // one decode lane per symbol position, first symbol in the top bits
    for (genvar j = 0; j < bocil_pkg::LANES; j++) begin : g_lane
        bocil_lane #(
            .LANE (j)
        ) u_lane (
            .i_sym           (i_packed_word[bocil_pkg::WORD_W-1-j*bocil_pkg::SYM_W -:
                                            bocil_pkg::SYM_W]),
            .i_valid_symbols (i_valid_symbols),
            .o_hit           (hits[j*bocil_pkg::NUM_SYMS +: bocil_pkg::NUM_SYMS])
        );
    end

    bocil_merge u_merge (
        .i_hits (hits),
        .o_incr (incr)
    );

    assign item.word       = i_packed_word;
    assign item.incr       = incr;
    assign item.final_word = i_final_word;
    assign item.ckpt       = (r_wii == '0);

    assign accept = i_in_valid && o_in_ready;

    // word position inside the interval, restarts after a final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wii <= '0;
        end else if (accept) begin
            if (i_final_word || (r_wii == WII_W'(WPI - 1))) begin
                r_wii <= '0;
            end else begin
                r_wii <= r_wii + WII_W'(1);
            end
        end
    end

    bocil_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_in_valid),
        .o_item_ready   (o_in_ready),
        .i_item         (item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word),
        .o_word_kind    (o_word_kind),
        .o_last_of_item (o_last_of_item),
        .o_index_end    (o_index_end)
    );

endmodule

`default_nettype wire

// File: rtl/bocil_checker.sv
// Port-level checker for the occurrence interleaver, bound to the top level.
// Depends on bocil_pkg and the assertion macro header.
`default_nettype none
`include "bwt_occurrence_checkpoint_interleaver_unit_macros.svh"

module bocil_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_ready,
    input wire logic [bocil_pkg::WORD_W-1:0]     i_packed_word,
    input wire logic [bocil_pkg::NVALID_W-1:0]   i_valid_symbols,
    input wire logic                             i_final_word,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [bocil_pkg::WORD_W-1:0]     o_out_word,
    input wire logic                             o_word_kind,
    input wire logic                             o_last_of_item,
    input wire logic                             o_index_end
);

    logic idx_end_shown;
    logic word_not_last;
    logic out_stall;

    assign idx_end_shown = o_out_valid && o_index_end;
    assign word_not_last = o_out_valid && i_out_ready &&
                           (o_word_kind == bocil_pkg::KIND_WORD) && !o_last_of_item;
    assign out_stall     = o_out_valid && !i_out_ready;

    // index end closes its transaction's results and is a count half
    `BOCIL_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, idx_end_shown, o_last_of_item)
    `BOCIL_ASSERT_IMP(a_end_is_count, i_clk, i_rst_n, idx_end_shown,
                      o_word_kind == bocil_pkg::KIND_COUNT)
    // a passed word that is not last is followed only by closing count halves
    `BOCIL_ASSERT_NEXT(a_closing_follows, i_clk, i_rst_n, word_not_last,
                       !o_out_valid || (o_word_kind == bocil_pkg::KIND_COUNT))
    // stalled result holds
    `BOCIL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
                       o_out_valid && $stable(o_out_word) && $stable(o_word_kind))

endmodule

bind bwt_occurrence_checkpoint_interleaver_unit bocil_checker u_bocil_checker (.*);

`default_nettype wire

// File: tb/bwt_occurrence_checkpoint_interleaver_unit_test.sv
// Self-checking testbench for the occurrence checkpoint interleaver: directed and random
// packed-word sequences, a scoreboard class that predicts every emitted word, and a watchdog.
// Depends on bocil_pkg and bwt_occurrence_checkpoint_interleaver_unit.

// One emitted word as the block should produce it
typedef struct {
    logic [bocil_pkg::WORD_W-1:0] out_word;
    logic                         word_kind;
    logic                         last_of_item;
    logic                         index_end;
} t_occ_word;

// Running occurrence counts and the queue of words still to be emitted
class occ_stream_checker #(int INTERVAL = bocil_pkg::DEF_INTERVAL);
    localparam int WORDS_PER_CKPT = (INTERVAL / 16 == 0) ? 1 : INTERVAL / 16;

    t_occ_word                       expected_q[$];
    logic [bocil_pkg::COUNT_W-1:0]   sym_count [bocil_pkg::NUM_SYMS];
    int unsigned                     slot;
    int unsigned                     mismatches;
    int unsigned                     results_seen;
    int unsigned                     words_in;
    int unsigned                     checkpoints;
    int unsigned                     sequences;

    function new();
        clear_state();
        mismatches   = 0;
        results_seen = 0;
        words_in     = 0;
        checkpoints  = 0;
        sequences    = 0;
    endfunction

    function void clear_state();
        foreach (sym_count[s]) sym_count[s] = '0;
        slot = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Eight count halves, low half first; flags only on the closing record
    function void push_counts(logic closing);
        t_occ_word e;
        for (int s = 0; s < bocil_pkg::NUM_SYMS; s++) begin
            for (int h = 0; h < 2; h++) begin
                e.out_word     = h ? sym_count[s][63:32] : sym_count[s][31:0];
                e.word_kind    = bocil_pkg::KIND_COUNT;
                e.last_of_item = closing && (s == bocil_pkg::NUM_SYMS - 1) && (h == 1);
                e.index_end    = e.last_of_item;
                expected_q.push_back(e);
            end
        end
        checkpoints++;
    endfunction

    // Accepted input transaction: queue what it causes, then update the counts
    function void absorb_word(logic [31:0] word, logic [4:0] nvalid, logic fin);
        t_occ_word   e;
        int unsigned nv;
        logic [1:0]  sym;
        nv = (nvalid > 5'd16) ? 16 : nvalid;
        words_in++;
        if (slot == 0) push_counts(1'b0);
        e.out_word     = word;
        e.word_kind    = bocil_pkg::KIND_WORD;
        e.last_of_item = !fin;
        e.index_end    = 1'b0;
        expected_q.push_back(e);
        for (int j = 0; j < nv; j++) begin
            sym = word[(15 - j) * 2 +: 2];
            sym_count[sym] = sym_count[sym] + 64'd1;
        end
        slot++;
        if (slot >= WORDS_PER_CKPT) slot = 0;
        if (fin) begin
            push_counts(1'b1);
            clear_state();
            sequences++;
        end
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_emitted(logic [31:0] word, logic kind, logic last, logic iend);
        t_occ_word e;
        results_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected word %h kind %b last %b end %b",
                         word, kind, last, iend);
            return;
        end
        e = expected_q.pop_front();
        if (e.out_word !== word || e.word_kind !== kind ||
            e.last_of_item !== last || e.index_end !== iend) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp word %h kind %b last %b end %b, got %h %b %b %b",
                         results_seen, e.out_word, e.word_kind, e.last_of_item, e.index_end,
                         word, kind, last, iend);
        end
    endfunction
endclass

module bwt_occurrence_checkpoint_interleaver_unit_test;

    localparam int CKPT_INTERVAL = bocil_pkg::DEF_INTERVAL;
    localparam int RANDOM_ITEMS  = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_in_valid      = 1'b0;
    logic [bocil_pkg::WORD_W-1:0]      i_packed_word   = '0;
    logic [bocil_pkg::NVALID_W-1:0]    i_valid_symbols = '0;
    logic                              i_final_word    = 1'b0;
    logic                              i_out_ready     = 1'b0;
    logic                              o_in_ready;
    logic                              o_out_valid;
    logic [bocil_pkg::WORD_W-1:0]      o_out_word;
    logic                              o_word_kind;
    logic                              o_last_of_item;
    logic                              o_index_end;

    occ_stream_checker #(CKPT_INTERVAL) sb;

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit          no_gaps    = 1'b0;
    int unsigned quiet_cnt  = 0;

    // Receiver pattern state
    int unsigned rx_mode  = 0;
    int unsigned rx_left  = 0;
    int unsigned rx_tick  = 0;
    int unsigned rx_stall = 0;

    bwt_occurrence_checkpoint_interleaver_unit #(
        .CHECKPOINT_INTERVAL(CKPT_INTERVAL)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packed_word   (i_packed_word),
        .i_valid_symbols (i_valid_symbols),
        .i_final_word    (i_final_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_word      (o_out_word),
        .o_word_kind     (o_word_kind),
        .o_last_of_item  (o_last_of_item),
        .o_index_end     (o_index_end)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: modes of always ready, random, periodic and long stalls
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(3, 0);
            rx_left <= $urandom_range(256, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= ($urandom_range(3, 0) != 0);
            end
            2: begin
                i_out_ready <= (rx_tick % 3 == 0);
            end
            default: begin
                if (rx_stall != 0) begin
                    i_out_ready <= 1'b0;
                    rx_stall    <= rx_stall - 1;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(9, 0) == 0) rx_stall <= $urandom_range(20, 1);
                end
            end
        endcase
    end

    // Monitor both channels and watch for a stuck handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.absorb_word(i_packed_word, i_valid_symbols, i_final_word);
            if (o_out_valid && i_out_ready)
                sb.check_emitted(o_out_word, o_word_kind, o_last_of_item, o_index_end);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles, %0d words outstanding",
                         STALL_LIMIT, sb.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Present one word and hold it until it is taken
    task automatic send_word(input logic [31:0] word, input logic [4:0] nvalid,
                             input logic fin);
        i_in_valid      <= 1'b1;
        i_packed_word   <= word;
        i_valid_symbols <= nvalid;
        i_final_word    <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Burst pacing: random gap between bursts unless in a gap-free stretch
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(12, 0);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
    endtask

    // Hold off the sender until every queued word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned len;
        int unsigned pick;
        logic [4:0]  nv;
        logic [31:0] w;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-word sequences at the field extremes
        send_word(32'h0000_0000, 5'd16, 1'b1);
        send_word(32'hFFFF_FFFF, 5'd16, 1'b1);
        send_word(32'h1B1B_1B1B, 5'd0, 1'b1);   // no valid symbols, still passed
        send_word(32'hE4E4_E4E4, 5'd31, 1'b1);  // above sixteen, clipped
        send_word(32'h5555_AAAA, 5'd17, 1'b1);
        send_word(32'hDEAD_BEEF, 5'd1, 1'b1);   // unused bits pass through
        // Directed: one sequence across a checkpoint with short non-final words
        for (int i = 0; i < 11; i++) begin
            case (i)
                1:       nv = 5'd5;
                3:       nv = 5'd0;
                5:       nv = 5'd3;
                8:       nv = 5'd31;
                default: nv = 5'd16;
            endcase
            w = (i % 2) ? 32'hFFFF_FFFF : $urandom;
            send_word(w, nv, i == 10);
        end
        drain();

        // Random: well-formed sequences of random content and length
        while (items_sent < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(4, 0) == 0);
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99, 0);
                if (pick < 65)      nv = 5'd16;
                else if (pick < 85) nv = $urandom_range(15, 1);
                else                nv = $urandom_range(31, 0);
                pace();
                send_word($urandom, nv, i == len - 1);
            end
            if ($urandom_range(7, 0) == 0) drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transactions in %0d sequences with %0d count records,",
                 sb.words_in, sb.sequences, sb.checkpoints);
        $display("%0d output transactions checked, %0d mismatches, %0d left outstanding.",
                 sb.results_seen, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/bocil_pkg.sv
rtl/bocil_lane.sv
rtl/bocil_merge.sv
rtl/bocil_emit.sv
rtl/bwt_occurrence_checkpoint_interleaver_unit.sv
rtl/bocil_checker.sv
tb/bwt_occurrence_checkpoint_interleaver_unit_test.sv
